[hw/rtl/arsv_pkg.sv]
// Package for the atomic store value recompute unit.
// Holds the item types, the zero register number and the atomic opcode codes.
// No dependencies.
package arsv_pkg;

	// Register number that reads as zero and never aliases the base
	localparam logic [4:0] REG_ZERO = 5'h1F;

	// Atomic opcode field (opc, bits 14:12); o3 set with OPC_ADD selects swap
	typedef enum logic [2:0] {
		OPC_ADD, OPC_CLR, OPC_EOR, OPC_SET, OPC_SMAX, OPC_SMIN, OPC_UMAX, OPC_UMIN
	} amo_op_t;

	// Request item: one atomic store access with its source operands
	typedef struct packed {
		logic        is_rmw_form;
		logic [31:0] instr_word;
		logic [4:0]  base_reg;
		logic [63:0] base_value;
		logic [63:0] old_value;
		logic [3:0]  size_bytes;
		logic [63:0] rs_value;
		logic [63:0] rt_value;
	} req_t;

	// Response item: recomputed store value and whether it applies
	typedef struct packed {
		logic        fix_needed;
		logic [63:0] store_value;
	} rsp_t;

endpackage

[hw/rtl/arsv_alu.sv]
// Combinational datapath of the atomic store value recompute unit.
// Decodes the atomic form, substitutes the base value for aliased sources
// and computes the store value. Depends on arsv_pkg.
module arsv_alu (
	input  arsv_pkg::req_t req,
	output arsv_pkg::rsp_t rsp
);

	// Byte mask for the access size; eight and above use the full word
	function automatic logic [63:0] size_mask(input logic [3:0] sz);
		logic [63:0] m;
		begin
			case (sz)
				4'd0: m = 64'h0;
				4'd1: m = 64'h0000_0000_0000_00FF;
				4'd2: m = 64'h0000_0000_0000_FFFF;
				4'd3: m = 64'h0000_0000_00FF_FFFF;
				4'd4: m = 64'h0000_0000_FFFF_FFFF;
				4'd5: m = 64'h0000_00FF_FFFF_FFFF;
				4'd6: m = 64'h0000_FFFF_FFFF_FFFF;
				4'd7: m = 64'h00FF_FFFF_FFFF_FFFF;
				default: m = {64{1'b1}};
			endcase
			return m;
		end
	endfunction

	// Sign-extend from the top bit of the last byte of the access
	function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] sz);
		logic [63:0] e;
		begin
			case (sz)
				4'd0: e = 64'h0;
				4'd1: e = {{56{v[7]}},  v[7:0]};
				4'd2: e = {{48{v[15]}}, v[15:0]};
				4'd3: e = {{40{v[23]}}, v[23:0]};
				4'd4: e = {{32{v[31]}}, v[31:0]};
				4'd5: e = {{24{v[39]}}, v[39:0]};
				4'd6: e = {{16{v[47]}}, v[47:0]};
				4'd7: e = {{8{v[55]}},  v[55:0]};
				default: e = v;
			endcase
			return e;
		end
	endfunction

	logic [4:0]         rs;
	logic [4:0]         rt;
	logic               o3;
	arsv_pkg::amo_op_t  opc;
	logic [63:0]        mask;
	logic [63:0]        old;
	logic [63:0]        s;
	logic [63:0]        old_ext;
	logic [63:0]        s_ext;
	logic               rs_alias;
	logic               rt_alias;
	logic [63:0]        rsv;
	logic [63:0]        rtv;
	logic [63:0]        rmw_val;
	logic [63:0]        cas_val;
	logic               fix;

	// Decode fields and alias checks; register 31 never aliases
	assign rs       = req.instr_word[20:16];
	assign rt       = req.instr_word[4:0];
	assign o3       = req.instr_word[15];
	assign opc      = arsv_pkg::amo_op_t'(req.instr_word[14:12]);
	assign rs_alias = (rs == req.base_reg) && (rs != arsv_pkg::REG_ZERO);
	assign rt_alias = (rt == req.base_reg) && (rt != arsv_pkg::REG_ZERO);

	// Mask operands to the access size
	assign mask    = size_mask(req.size_bytes);
	assign old     = req.old_value & mask;
	assign s       = req.base_value & mask;
	assign old_ext = sext(old, req.size_bytes);
	assign s_ext   = sext(s, req.size_bytes);

	// Read-modify-write operation with the base value as source
	always_comb begin
		if (o3 && (opc == arsv_pkg::OPC_ADD)) begin
			rmw_val = s;
		end else begin
			case (opc)
				arsv_pkg::OPC_ADD:  rmw_val = old + s;
				arsv_pkg::OPC_CLR:  rmw_val = old & ~s;
				arsv_pkg::OPC_EOR:  rmw_val = old ^ s;
				arsv_pkg::OPC_SET:  rmw_val = old | s;
				arsv_pkg::OPC_SMAX: rmw_val = ($signed(old_ext) > $signed(s_ext)) ? old : s;
				arsv_pkg::OPC_SMIN: rmw_val = ($signed(old_ext) < $signed(s_ext)) ? old : s;
				arsv_pkg::OPC_UMAX: rmw_val = (old > s) ? old : s;
				arsv_pkg::OPC_UMIN: rmw_val = (old < s) ? old : s;
				default:            rmw_val = old;
			endcase
		end
	end

	// Compare-and-swap operands; register 31 reads zero
	always_comb begin
		if (rs_alias) begin
			rsv = req.base_value & mask;
		end else if (rs == arsv_pkg::REG_ZERO) begin
			rsv = 64'h0;
		end else begin
			rsv = req.rs_value & mask;
		end
		if (rt_alias) begin
			rtv = req.base_value & mask;
		end else if (rt == arsv_pkg::REG_ZERO) begin
			rtv = 64'h0;
		end else begin
			rtv = req.rt_value & mask;
		end
		cas_val = (old == rsv) ? rtv : old;
	end

	// Select the form; drop the value when no source that the form uses aliases (rs, or rs or rt for compare-and-swap)
	assign fix = req.is_rmw_form ? rs_alias : (rs_alias || rt_alias);

	always_comb begin
		rsp.fix_needed  = fix;
		rsp.store_value = '0;
		if (fix) begin
			rsp.store_value = (req.is_rmw_form ? rmw_val : cas_val) & mask;
		end
	end

endmodule

[hw/rtl/atomic_rmw_alias_store_value_unit.sv]
// Path: a request passes the input register, then the single-pass ALU and the
// result register before the response is offered.
// Throughput: one item per cycle while responses are taken; the result register frees the input stage
// whenever the response is taken or empty, so a stalled output holds one item each stage.
// Reset: arst_n clears both valid flags asynchronously; payload registers are not reset.
module atomic_rmw_alias_store_value_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  arsv_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output arsv_pkg::rsp_t rsp
);

	arsv_pkg::req_t req_s1;
	logic           valid_s1;
	arsv_pkg::rsp_t alu_rsp;
	arsv_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           load_rsp;

	// Advance when the result register is empty or being drained
	assign load_rsp  = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || load_rsp;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	arsv_alu u_alu (
		.req (req_s1),
		.rsp (alu_rsp)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp && valid_s1) begin
			rsp_q <= alu_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A response without a fix carries a zero value
	a_zero_without_fix: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.fix_needed |-> rsp_q.store_value == 64'h0)
		else $error("store value nonzero without fix");

	// A base of register 31 never takes a fix
	a_sp_base_no_fix: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_rsp && (req_s1.base_reg == arsv_pkg::REG_ZERO) |=> !rsp_q.fix_needed)
		else $error("fix reported with base register 31");

	// A zero access size always stores zero
	a_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_rsp && (req_s1.size_bytes == 4'd0) |=> rsp_q.store_value == 64'h0)
		else $error("nonzero store value at size zero");

	// An empty input stage never blocks the request side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("request stalled with empty input stage");

	// A stage that moves forward lands in the result register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_rsp |=> rsp_valid_q)
		else $error("item lost between stages");

endmodule

[sim/tb_top.sv]
// Testbench for atomic_rmw_alias_store_value_unit: directed table, then random items.
// Predicts each store value not given in the directed table and checks every response in order.
// Depends on arsv_pkg (req_t, rsp_t, amo_op_t, REG_ZERO) and the top-level RTL module.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ALL_ONES = ~64'd0;

	// One row of the directed table
	typedef struct {
		arsv_pkg::req_t item;
		bit             known;
		arsv_pkg::rsp_t want;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	arsv_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	arsv_pkg::rsp_t rsp;

	arsv_pkg::rsp_t store_q[$];
	dir_row_t       dir_rows[$];
	int             err_count = 0;
	int             send_idle;
	int             recv_idle;

	atomic_rmw_alias_store_value_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Generate the 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Bound the run
	initial begin
		#400000;
		$display("tb_top NOT OK");
		$finish;
	end

	// Mask of the low size bytes; sizes of eight and above use all 64 bits
	function automatic logic [63:0] size_mask(logic [3:0] size);
		int sz;
		sz = size;
		if (sz >= 8) return ALL_ONES;
		if (sz == 0) return 64'd0;
		return (64'd1 << (sz * 8)) - 64'd1;
	endfunction

	// Sign-extend from the top bit of the last byte of the access
	function automatic logic signed [63:0] sext_size(logic [63:0] v, logic [3:0] size);
		int sh;
		if (size == 4'd0) return 64'sd0;
		if (size >= 4'd8) return $signed(v);
		sh = 64 - int'(size) * 8;
		return $signed(v << sh) >>> sh;
	endfunction

	// Recompute the value the atomic store should leave in memory
	function automatic arsv_pkg::rsp_t predict_store(arsv_pkg::req_t r);
		logic [63:0]       mask;
		logic [63:0]       old;
		logic [63:0]       s;
		logic [63:0]       rsv;
		logic [63:0]       rtv;
		logic [63:0]       v;
		logic [4:0]        rs;
		logic [4:0]        rt;
		arsv_pkg::amo_op_t op;
		logic              o3;
		bit                rs_al;
		bit                rt_al;
		arsv_pkg::rsp_t    p;
		mask  = size_mask(r.size_bytes);
		old   = r.old_value & mask;
		rs    = r.instr_word[20:16];
		rt    = r.instr_word[4:0];
		o3    = r.instr_word[15];
		op    = arsv_pkg::amo_op_t'(r.instr_word[14:12]);
		rs_al = (rs == r.base_reg) && (rs != arsv_pkg::REG_ZERO);
		rt_al = (rt == r.base_reg) && (rt != arsv_pkg::REG_ZERO);
		v     = 64'd0;
		p.fix_needed = 1'b0;
		if (r.is_rmw_form) begin
			if (rs_al) begin
				s = r.base_value & mask;
				if (o3 && op == arsv_pkg::OPC_ADD) begin
					v = s;
				end else begin
					case (op)
						arsv_pkg::OPC_ADD:  v = old + s;
						arsv_pkg::OPC_CLR:  v = old & ~s;
						arsv_pkg::OPC_EOR:  v = old ^ s;
						arsv_pkg::OPC_SET:  v = old | s;
						arsv_pkg::OPC_SMAX: v = (sext_size(old, r.size_bytes) >
							sext_size(s, r.size_bytes)) ? old : s;
						arsv_pkg::OPC_SMIN: v = (sext_size(old, r.size_bytes) <
							sext_size(s, r.size_bytes)) ? old : s;
						arsv_pkg::OPC_UMAX: v = (old > s) ? old : s;
						default:            v = (old < s) ? old : s;
					endcase
				end
				p.fix_needed = 1'b1;
			end
		end else if (rs_al || rt_al) begin
			rsv = rs_al ? r.base_value :
				((rs == arsv_pkg::REG_ZERO) ? 64'd0 : r.rs_value);
			rtv = rt_al ? r.base_value :
				((rt == arsv_pkg::REG_ZERO) ? 64'd0 : r.rt_value);
			rsv = rsv & mask;
			rtv = rtv & mask;
			v = (old == rsv) ? rtv : old;
			p.fix_needed = 1'b1;
		end
		p.store_value = v & mask;
		return p;
	endfunction

	// Build an item from its decoded fields; unused instruction bits are random
	function automatic arsv_pkg::req_t mk_req(bit rmw, logic [4:0] rs, bit o3,
			arsv_pkg::amo_op_t op, logic [4:0] rt, logic [4:0] base, logic [63:0] bv,
			logic [63:0] old, logic [3:0] size, logic [63:0] rsv, logic [63:0] rtv);
		arsv_pkg::req_t r;
		logic [31:0]    w;
		w        = $urandom;
		w[20:16] = rs;
		w[15]    = o3;
		w[14:12] = op;
		w[4:0]   = rt;
		r.is_rmw_form = rmw;
		r.instr_word  = w;
		r.base_reg    = base;
		r.base_value  = bv;
		r.old_value   = old;
		r.size_bytes  = size;
		r.rs_value    = rsv;
		r.rt_value    = rtv;
		return r;
	endfunction

	function automatic arsv_pkg::rsp_t mk_rsp(logic fix, logic [63:0] val);
		arsv_pkg::rsp_t p;
		p.fix_needed  = fix;
		p.store_value = val;
		return p;
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 64'd0;
			1:       return ALL_ONES;
			2:       return 64'h8000_0000_0000_0000;
			3:       return 64'h7FFF_FFFF_FFFF_FFFF;
			4:       return 64'($urandom_range(0, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random item; most alias a source to the base so the ALU is exercised
	function automatic arsv_pkg::req_t gen_item();
		arsv_pkg::req_t r;
		logic [4:0]     rs;
		logic [4:0]     rt;
		logic [4:0]     base;
		logic [63:0]    src;
		rs   = 5'($urandom_range(0, 31));
		rt   = 5'($urandom_range(0, 31));
		base = ($urandom_range(0, 15) == 0) ? arsv_pkg::REG_ZERO :
			5'($urandom_range(0, 30));
		r.is_rmw_form = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 7) begin
			if (r.is_rmw_form || $urandom_range(0, 1)) rs = base;
			else rt = base;
			if (!r.is_rmw_form && $urandom_range(0, 3) == 0) begin
				rs = base;
				rt = base;
			end
		end
		r = mk_req(r.is_rmw_form, rs, 1'($urandom_range(0, 1)),
			arsv_pkg::amo_op_t'($urandom_range(0, 7)), rt, base, pick_value(),
			pick_value(), 4'd0, pick_value(), pick_value());
		if ($urandom_range(0, 3) == 0) r.size_bytes = 4'($urandom_range(0, 15));
		else r.size_bytes = 4'(1 << $urandom_range(0, 3));
		// In about a third of the items copy the compare source into the old value so the comparison can match
		if ($urandom_range(0, 2) == 0) begin
			src = (rs == base && rs != arsv_pkg::REG_ZERO) ? r.base_value :
				((rs == arsv_pkg::REG_ZERO) ? 64'd0 : r.rs_value);
			r.old_value = src;
			if ($urandom_range(0, 1)) r.old_value[63:32] = $urandom;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic add_row(arsv_pkg::req_t r, bit known, arsv_pkg::rsp_t want);
		dir_row_t d;
		d.item  = r;
		d.known = known;
		d.want  = want;
		dir_rows.push_back(d);
	endtask

	// Offer one item after random idle cycles and hold it until accepted
	task automatic send_item(arsv_pkg::req_t r, bit known, arsv_pkg::rsp_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!(req_valid && req_ready));
		store_q.push_back(known ? want : predict_store(r));
	endtask

	// Hold off new items until every expected response has arrived
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (store_q.size() != 0) @(posedge clk);
	endtask

	// Randomize the response side stall; hold ready low in reset
	always @(negedge clk) begin
		rsp_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	// Check each accepted response against the oldest expectation
	always @(posedge clk) begin
		arsv_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (store_q.size() == 0) begin
				report_mismatch("unexpected response", rsp.store_value, 64'd0);
			end else begin
				want = store_q.pop_front();
				if (rsp.fix_needed !== want.fix_needed)
					report_mismatch("fix_needed", 64'(rsp.fix_needed),
						64'(want.fix_needed));
				if (rsp.store_value !== want.store_value)
					report_mismatch("store_value", rsp.store_value, want.store_value);
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		send_idle = 9;
		recv_idle = 45;

		// Directed table: known answers where obvious, predictor elsewhere
		add_row(mk_req(1'b1, arsv_pkg::REG_ZERO, 1'b1, arsv_pkg::OPC_ADD, 5'd3,
			arsv_pkg::REG_ZERO, ALL_ONES, ALL_ONES, 4'd8, ALL_ONES, ALL_ONES),
			1'b1, mk_rsp(1'b0, 64'd0));
		add_row(mk_req(1'b0, 5'd1, 1'b0, arsv_pkg::OPC_ADD, 5'd2, 5'd3, ALL_ONES,
			ALL_ONES, 4'd8, ALL_ONES, ALL_ONES), 1'b1, mk_rsp(1'b0, 64'd0));
		add_row(mk_req(1'b1, 5'd5, 1'b1, arsv_pkg::OPC_ADD, 5'd0, 5'd5, ALL_ONES,
			64'd0, 4'd8, 64'd0, 64'd0), 1'b1, mk_rsp(1'b1, ALL_ONES));
		add_row(mk_req(1'b1, 5'd5, 1'b1, arsv_pkg::OPC_ADD, 5'd0, 5'd5, ALL_ONES,
			ALL_ONES, 4'd0, ALL_ONES, ALL_ONES), 1'b1, mk_rsp(1'b1, 64'd0));
		add_row(mk_req(1'b1, 5'd0, 1'b1, arsv_pkg::OPC_ADD, 5'd9, 5'd0, ALL_ONES,
			64'd0, 4'd1, 64'd0, 64'd0), 1'b1, mk_rsp(1'b1, 64'hFF));
		add_row(mk_req(1'b1, 5'd7, 1'b0, arsv_pkg::OPC_ADD, 5'd9, 5'd7, 64'd1,
			64'hFFFF, 4'd2, 64'd0, 64'd0), 1'b1, mk_rsp(1'b1, 64'd0));
		add_row(mk_req(1'b1, 5'd4, 1'b0, arsv_pkg::OPC_ADD, 5'd9, 5'd9, ALL_ONES,
			ALL_ONES, 4'd8, ALL_ONES, ALL_ONES), 1'b1, mk_rsp(1'b0, 64'd0));
		for (int op = 0; op < 8; op++) begin
			add_row(mk_req(1'b1, 5'd30, 1'b0, arsv_pkg::amo_op_t'(op), 5'd1, 5'd30,
				64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8,
				64'd0, 64'd0), 1'b0, '0);
		end
		add_row(mk_req(1'b1, 5'd2, 1'b0, arsv_pkg::OPC_SMAX, 5'd1, 5'd2,
			64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF, 4'd4, 64'd0, 64'd0),
			1'b0, '0);
		add_row(mk_req(1'b1, 5'd2, 1'b0, arsv_pkg::OPC_SMIN, 5'd1, 5'd2, 64'h0080_0000,
			64'h007F_FFFF, 4'd3, 64'd0, 64'd0), 1'b0, '0);
		add_row(mk_req(1'b1, 5'd2, 1'b0, arsv_pkg::OPC_SMAX, 5'd1, 5'd2, 64'hFF_FFFF_FFFF,
			64'h01, 4'd5, 64'd0, 64'd0), 1'b0, '0);
		add_row(mk_req(1'b1, 5'd2, 1'b0, arsv_pkg::OPC_SMIN, 5'd1, 5'd2,
			64'h80_0000_0000_0000, 64'hFF7F_FFFF_FFFF_FFFF, 4'd7, 64'd0, 64'd0),
			1'b0, '0);
		add_row(mk_req(1'b1, 5'd2, 1'b0, arsv_pkg::OPC_UMAX, 5'd1, 5'd2, ALL_ONES,
			64'd5, 4'd15, 64'd0, 64'd0), 1'b0, '0);
		add_row(mk_req(1'b0, 5'd6, 1'b0, arsv_pkg::OPC_ADD, 5'd8, 5'd6, 64'h1234,
			64'h1234, 4'd2, 64'd0, 64'hBEEF), 1'b0, '0);
		add_row(mk_req(1'b0, 5'd6, 1'b0, arsv_pkg::OPC_ADD, 5'd8, 5'd8, 64'h55, 64'h99,
			4'd1, 64'h77, 64'd0), 1'b0, '0);
		add_row(mk_req(1'b0, 5'd8, 1'b0, arsv_pkg::OPC_ADD, 5'd8, 5'd8, ALL_ONES,
			ALL_ONES, 4'd6, 64'd0, 64'd0), 1'b0, '0);
		add_row(mk_req(1'b0, arsv_pkg::REG_ZERO, 1'b0, arsv_pkg::OPC_ADD, 5'd11, 5'd11,
			64'hAAAA_5555, 64'd0, 4'd4, ALL_ONES, 64'd0), 1'b0, '0);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
		drain_responses();

		// Random items in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 9 : ((ph == 1) ? 45 : 0);
			recv_idle = (ph == 0) ? 45 : ((ph == 1) ? 9 : 0);
			for (int n = 0; n < 300; n++) send_item(gen_item(), 1'b0, '0);
			drain_responses();
		end

		repeat (10) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
